// File: rtl/assert_macros.svh
// Assertion helpers, sampled on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CSRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CSRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/csrp_pkg.sv
`timescale 1ns / 1ps

package csrp_pkg;

  localparam int WAYS_DEFAULT     = 8;
  localparam int TAG_BITS_DEFAULT = 32;

  localparam int WAY_W = 3;
  localparam int TAG_W = 32;

  typedef enum logic [1:0] {
    MODE_ACCESS = 2'd0,
    MODE_VICTIM = 2'd1,
    MODE_FILL   = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  // POL_SPARE selects victims like FIFO
  typedef enum logic [1:0] {
    POL_RANDOM = 2'd0,
    POL_FIFO   = 2'd1,
    POL_LRU    = 2'd2,
    POL_SPARE  = 2'd3
  } policy_t;

  typedef struct packed {
    mode_t             mode;
    logic [WAY_W-1:0]  way;
    logic [TAG_W-1:0]  tag_in;
    logic [WAY_W-1:0]  random_way;
  } req_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag_out;
    logic              valid_out;
    logic [WAY_W-1:0]  victim_way;
  } rsp_t;

endpackage

// File: rtl/csrp_channels.sv
`timescale 1ns / 1ps

interface csrp_req_if;
  logic              valid;
  logic              ready;
  csrp_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface csrp_rsp_if;
  logic              valid;
  logic              ready;
  csrp_pkg::rsp_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface csrp_cfg_if;
  logic              valid;
  logic              ready;
  csrp_pkg::policy_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/cache_set_replacement_policy.sv
// One cache set with random, FIFO or LRU replacement. Requests enter an input register,
// the set state (tags, valid bits, order list, counters) is read and updated in one
// combinational pass, and the response lands in an output register, once any earlier
// response has left on rsp.ready. With rsp.ready high a new request can be taken every
// cycle. While a response waits on rsp.ready, one more request is held in the input
// register and req.ready then drops until the response leaves. The order list updates by
// a parallel match and shift across all WAYS entries, which sets the critical path. The
// policy register resets to FIFO; the user must write it through the cfg channel while
// the block is idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cache_set_replacement_policy #(
  parameter int WAYS     = csrp_pkg::WAYS_DEFAULT,
  parameter int TAG_BITS = csrp_pkg::TAG_BITS_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  csrp_cfg_if.sink    cfg,
  csrp_req_if.sink    req,
  csrp_rsp_if.source  rsp
);
  import csrp_pkg::*;

  localparam int WIDX       = $clog2(WAYS);
  localparam int CW         = $clog2(WAYS + 1);
  localparam int STORE_BITS = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

  policy_t                 policy;
  logic                    s1_valid;
  req_t                    s1_req;
  logic                    out_valid;
  rsp_t                    out_data;
  logic [STORE_BITS-1:0]   tag_store [WAYS];
  logic [WAYS-1:0]         valid_bits;
  logic [WIDX-1:0]         order_list [WAYS];
  logic [CW-1:0]           order_count;
  logic [CW-1:0]           used_count;

  logic                    advance;
  logic                    way_ok;
  logic [WIDX-1:0]         w_idx;
  logic                    free_way;
  logic                    fill;
  logic                    append;
  logic [WAYS-1:0]         find_hot;
  logic [WAYS-1:0]         rem_hot;
  logic [CW-1:0]           cnt_rem;
  logic [WIDX-1:0]         order_list_next [WAYS];
  logic [CW-1:0]           order_count_next;
  logic [CW-1:0]           used_count_next;
  rsp_t                    result;

  function automatic logic [WAY_W-1:0] random_reduce(input logic [WAY_W-1:0] r);
    logic [WAY_W:0] v;
    v = {1'b0, r};
    // r < 8 and WAYS >= 2, so four subtractions always suffice
    for (int k = 0; k < 4; k++) begin
      if (int'(v) >= WAYS) begin
        v = v - (WAY_W + 1)'(WAYS);
      end
    end
    return v[WAY_W-1:0];
  endfunction

  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign way_ok   = int'(s1_req.way) < WAYS;
  assign w_idx    = WIDX'(s1_req.way);
  assign free_way = used_count < CW'(WAYS);

  // first matching position of the addressed way in the order list
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < WAYS; i++) begin
      find_hot[i] = !seen && (CW'(i) < order_count) && (order_list[i] == w_idx);
      seen        = seen | find_hot[i];
    end
  end

  always_comb begin
    result          = '0;
    rem_hot         = '0;
    append          = 1'b0;
    fill            = 1'b0;
    used_count_next = used_count;
    unique case (s1_req.mode)
      MODE_ACCESS: begin
        if (way_ok) begin
          // tags are only ever written together with their valid bit
          result.valid_out = valid_bits[w_idx];
          result.tag_out   = valid_bits[w_idx] ? TAG_W'(tag_store[w_idx]) : '0;
          if (policy == POL_LRU && |find_hot) begin
            rem_hot = find_hot;
            append  = 1'b1;
          end
        end
      end
      MODE_VICTIM: begin
        if (free_way) begin
          result.victim_way = WAY_W'(used_count);
        end else if (policy == POL_RANDOM) begin
          result.victim_way = random_reduce(s1_req.random_way);
        end else if (order_count != '0) begin
          result.victim_way = WAY_W'(order_list[0]);
          rem_hot           = WAYS'(1);
        end
      end
      MODE_FILL: begin
        if (way_ok) begin
          fill    = 1'b1;
          rem_hot = find_hot;
          append  = 1'b1;
          if (!valid_bits[w_idx] && free_way) begin
            used_count_next = used_count + CW'(1);
          end
        end
      end
      MODE_NOP: begin
      end
    endcase
  end

  // remove one entry by shifting newer ones forward, then append at the tail
  always_comb begin
    logic after;
    after   = 1'b0;
    cnt_rem = order_count - CW'(|rem_hot);
    for (int i = 0; i < WAYS; i++) begin
      after = after | rem_hot[i];
      if (after && (i + 1 < WAYS)) begin
        order_list_next[i] = order_list[(i + 1) % WAYS];
      end else begin
        order_list_next[i] = order_list[i];
      end
    end
    order_count_next = cnt_rem;
    if (append && cnt_rem < CW'(WAYS)) begin
      for (int i = 0; i < WAYS; i++) begin
        if (CW'(i) == cnt_rem) begin
          order_list_next[i] = w_idx;
        end
      end
      order_count_next = cnt_rem + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= POL_FIFO;
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      valid_bits  <= '0;
      order_count <= '0;
      used_count  <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        policy <= cfg.data;
      end
      if (req.valid && req.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid   <= 1'b1;
        order_count <= order_count_next;
        used_count  <= used_count_next;
        if (fill) begin
          valid_bits[w_idx] <= 1'b1;
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req <= req.data;
    end
    if (advance) begin
      out_data <= result;
      for (int i = 0; i < WAYS; i++) begin
        order_list[i] <= order_list_next[i];
      end
      if (fill) begin
        tag_store[w_idx] <= s1_req.tag_in[STORE_BITS-1:0];
      end
    end
  end

  `CSRP_ASSERT_NOW(a_used_cnt, 1'b1, $countones(valid_bits) == int'(used_count), "used_count off")
  `CSRP_ASSERT_NOW(a_order_bound, 1'b1, order_count <= CW'(WAYS), "order list overfilled")
  `CSRP_ASSERT_NEXT(a_used_mono, 1'b1, used_count >= $past(used_count), "used_count fell")
  `CSRP_ASSERT_NEXT(a_result_follows, advance, out_valid, "response register not loaded")

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import csrp_pkg::*;

  localparam int WAYS = WAYS_DEFAULT;

  typedef struct packed {
    logic    is_cfg;
    policy_t pol;
    req_t    req;
    logic    fixed;
    rsp_t    want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  csrp_cfg_if cfg_ch ();
  csrp_req_if req_ch ();
  csrp_rsp_if rsp_ch ();

  cache_set_replacement_policy i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the set
  logic [TAG_W-1:0] tag_copy [WAYS];
  bit               valid_copy [WAYS];
  logic [WAY_W-1:0] age_q [$];       // oldest at the front
  int               used_ways;
  policy_t          policy_copy;

  rsp_t pending_replies [$];
  int   bad_replies = 0;
  logic want_fixed;
  rsp_t want_reply;
  int   burst_left = 0;

  task automatic predict_set_reply(input req_t r, output rsp_t o);
    int pos;
    o = '0;
    pos = -1;
    case (r.mode)
      MODE_ACCESS: begin
        if (policy_copy == POL_LRU) begin
          for (int i = 0; i < age_q.size(); i++)
            if (age_q[i] == r.way && pos < 0) pos = i;
          if (pos >= 0) begin
            age_q.delete(pos);
            age_q.insert(age_q.size(), r.way);
          end
        end
        o.tag_out   = tag_copy[r.way];
        o.valid_out = valid_copy[r.way];
      end
      MODE_VICTIM: begin
        if (used_ways < WAYS) begin
          o.victim_way = used_ways[WAY_W-1:0];
        end else if (policy_copy == POL_RANDOM) begin
          o.victim_way = WAY_W'(r.random_way % WAYS);
        end else if (age_q.size() > 0) begin
          o.victim_way = age_q[0];
          age_q.delete(0);
        end
      end
      MODE_FILL: begin
        if (!valid_copy[r.way] && used_ways < WAYS) used_ways++;
        valid_copy[r.way] = 1'b1;
        tag_copy[r.way]   = r.tag_in;
        for (int i = 0; i < age_q.size(); i++)
          if (age_q[i] == r.way && pos < 0) pos = i;
        if (pos >= 0) age_q.delete(pos);
        if (age_q.size() < WAYS) age_q.insert(age_q.size(), r.way);
      end
      default: ;
    endcase
  endtask

  // all handshakes observed in one place so ordering within the edge is fixed
  always @(posedge clk) begin
    rsp_t got, guess, exp_r;
    if (rst) begin
      for (int i = 0; i < WAYS; i++) begin
        tag_copy[i]   = '0;
        valid_copy[i] = 1'b0;
      end
      age_q.delete();
      used_ways   = 0;
      policy_copy = POL_FIFO;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) policy_copy = cfg_ch.data;
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        if (pending_replies.size() == 0) begin
          bad_replies++;
          if (bad_replies <= 10)
            $display("unexpected reply: tag %h valid %b victim %0d",
                     got.tag_out, got.valid_out, got.victim_way);
        end else begin
          exp_r = pending_replies[0];
          pending_replies.delete(0);
          if (got.tag_out !== exp_r.tag_out || got.valid_out !== exp_r.valid_out ||
              got.victim_way !== exp_r.victim_way) begin
            bad_replies++;
            if (bad_replies <= 10)
              $display("mismatch: exp tag %h v %b vic %0d, got tag %h v %b vic %0d",
                       exp_r.tag_out, exp_r.valid_out, exp_r.victim_way,
                       got.tag_out, got.valid_out, got.victim_way);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        predict_set_reply(req_ch.data, guess);
        pending_replies.insert(pending_replies.size(), want_fixed ? want_reply : guess);
      end
    end
  end

  // response back-pressure: styles change every so often
  int rx_style = 0, rx_left = 0, stall_left = 0;
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_style = $urandom_range(0, 2);
      rx_left  = $urandom_range(50, 200);
    end else begin
      rx_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (rx_style == 2 && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 12);
      rsp_ch.ready <= 1'b0;
    end else if (rx_style == 1) begin
      rsp_ch.ready <= 1'($urandom_range(0, 1));
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(input req_t r, input logic fixed, input rsp_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    want_fixed   <= fixed;
    want_reply   <= want;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_replies.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_policy(input policy_t p);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= p;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [TAG_W-1:0] rand_tag();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random(input mode_t m, input logic [WAY_W-1:0] w);
    req_t r;
    r.mode       = m;
    r.way        = w;
    r.tag_in     = rand_tag();
    r.random_way = WAY_W'($urandom_range(0, 7));
    send_request(r, 1'b0, '0);
  endtask

  function automatic dir_row_t req_row(input mode_t m, input logic [WAY_W-1:0] w,
                                       input logic [TAG_W-1:0] t,
                                       input logic [WAY_W-1:0] rw);
    dir_row_t d;
    d = '0;
    d.pol            = POL_FIFO;
    d.req.mode       = m;
    d.req.way        = w;
    d.req.tag_in     = t;
    d.req.random_way = rw;
    return d;
  endfunction

  function automatic dir_row_t fixed_row(input mode_t m, input logic [WAY_W-1:0] w,
                                         input logic [TAG_W-1:0] t,
                                         input logic [WAY_W-1:0] rw,
                                         input logic [TAG_W-1:0] et, input logic ev,
                                         input logic [WAY_W-1:0] evic);
    dir_row_t d;
    d = req_row(m, w, t, rw);
    d.fixed           = 1'b1;
    d.want.tag_out    = et;
    d.want.valid_out  = ev;
    d.want.victim_way = evic;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(input policy_t p);
    dir_row_t d;
    d = '0;
    d.is_cfg = 1'b1;
    d.pol    = p;
    return d;
  endfunction

  initial begin
    dir_row_t dir_rows [$];
    policy_t  phase_pol [8];
    int       sent, pick;
    bit       drain;
    logic [WAY_W-1:0] w;

    rst          = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = POL_FIFO;
    rsp_ch.ready = 1'b0;
    want_fixed   = 1'b0;
    want_reply   = '0;

    // reset policy is FIFO; free ways are handed out by used count
    dir_rows.insert(dir_rows.size(), fixed_row(MODE_ACCESS, 0, 0, 0, 32'h0, 1'b0, 0));
    dir_rows.insert(dir_rows.size(), fixed_row(MODE_VICTIM, 0, 0, 7, 32'h0, 1'b0, 0));
    dir_rows.insert(dir_rows.size(), fixed_row(MODE_NOP, 7, '1, 7, 32'h0, 1'b0, 0));
    dir_rows.insert(dir_rows.size(), fixed_row(MODE_FILL, 7, '1, 0, 32'h0, 1'b0, 0));
    dir_rows.insert(dir_rows.size(), fixed_row(MODE_ACCESS, 7, 0, 0, 32'hffff_ffff, 1'b1, 0));
    // free way still wins over the random choice
    dir_rows.insert(dir_rows.size(), cfg_row(POL_RANDOM));
    dir_rows.insert(dir_rows.size(), fixed_row(MODE_VICTIM, 0, 0, 6, 32'h0, 1'b0, 1));
    dir_rows.insert(dir_rows.size(), cfg_row(POL_FIFO));
    dir_rows.insert(dir_rows.size(), req_row(MODE_FILL, 0, 32'h0, 0));
    // refill moves way 7 back
    dir_rows.insert(dir_rows.size(), req_row(MODE_FILL, 7, 32'h5a5a_5a5a, 0));
    for (int i = 1; i < 7; i++)
      dir_rows.insert(dir_rows.size(), req_row(MODE_FILL, WAY_W'(i), 32'h1111_1111 * i, 0));
    dir_rows.insert(dir_rows.size(), req_row(MODE_VICTIM, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), cfg_row(POL_LRU));
    dir_rows.insert(dir_rows.size(), req_row(MODE_ACCESS, 7, 0, 0));
    dir_rows.insert(dir_rows.size(), req_row(MODE_VICTIM, 0, 0, 0));
    // way not in order list
    dir_rows.insert(dir_rows.size(), req_row(MODE_ACCESS, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), cfg_row(POL_RANDOM));
    dir_rows.insert(dir_rows.size(), fixed_row(MODE_VICTIM, 0, 0, 7, 32'h0, 1'b0, 7));
    dir_rows.insert(dir_rows.size(), fixed_row(MODE_VICTIM, 0, 0, 0, 32'h0, 1'b0, 0));
    // spare policy: FIFO victims, no reorder on access
    dir_rows.insert(dir_rows.size(), cfg_row(POL_SPARE));
    dir_rows.insert(dir_rows.size(), req_row(MODE_ACCESS, 2, 0, 0));
    dir_rows.insert(dir_rows.size(), req_row(MODE_VICTIM, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), fixed_row(MODE_NOP, 0, 0, 0, 32'h0, 1'b0, 0));

    phase_pol = '{POL_LRU, POL_RANDOM, POL_FIFO, POL_SPARE,
                  POL_LRU, POL_FIFO, POL_RANDOM, POL_LRU};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_drained();
        write_policy(dir_rows[i].pol);
      end else begin
        send_request(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].want);
      end
    end

    drain = 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      write_policy(phase_pol[ph]);
      sent = 0;
      while (sent < 200) begin
        // victim-heavy stretches empty the order list
        if ($urandom_range(0, 39) == 0) drain = !drain;
        pick = $urandom_range(0, 99);
        w    = WAY_W'($urandom_range(0, 7));
        if (drain && pick < 50) begin
          send_random(MODE_VICTIM, w);
          sent++;
        end else if (pick < 35) begin
          // miss: victim request, fill, then hit on the filled way
          send_random(MODE_VICTIM, w);
          send_random(MODE_FILL, w);
          send_random(MODE_ACCESS, w);
          sent += 3;
        end else if (pick < 65) begin
          send_random(MODE_ACCESS, w);
          sent++;
        end else if (pick < 85) begin
          send_random(MODE_FILL, w);
          sent++;
        end else if (pick < 95) begin
          send_random(MODE_VICTIM, w);
          sent++;
        end else begin
          send_random(MODE_NOP, w);
          sent++;
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (bad_replies == 0 && pending_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
